// ===== rtl/core/wsd_pkg.sv =====
// Package for the window stability detector: shared types and constants.
// No dependencies.
package wsd_pkg;

   localparam int DataWidth = 32;
   localparam int EpsWidth = 16;
   localparam int NumAxes = 3;
   localparam logic [31:0] SatMax = 32'hFFFF_FFFF;

   // Configuration register indexes.
   localparam logic [1:0] RegThreshold = 2'd0;
   localparam logic [1:0] RegEpsilon = 2'd1;
   localparam logic [1:0] RegUnstable = 2'd2;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_PREP,
      ST_DIV,
      ST_MERGE,
      ST_OUT
   } state_type;

   // Per-lane result handed to the merge stage.
   typedef struct packed {
      logic [31:0] term;
      logic [31:0] mean;
   } lane_result_type;

   // Control from the sequencer to the lanes.
   typedef struct packed {
      logic clear;
      logic accum;
      logic prep;
      logic div_step;
   } lane_ctrl_type;

endpackage

// ===== rtl/core/wsd_lane.sv =====
// One axis lane: accumulates sum and sum of squares over the window, then
// forms the normalized variance with a bit-serial divider. Uses wsd_pkg.
module wsd_lane
   import wsd_pkg::*;
#(
   parameter int Window = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lane_ctrl_type         ctrl,
   input  logic [31:0]           sample,
   input  logic [EpsWidth-1:0]   epsilon,
   output lane_result_type       result
);

   localparam int SumW = 32 + $clog2(Window) + 1;
   localparam int SqW = 64 + $clog2(Window) + 1;
   localparam int NumW = SqW + 8 + 16;
   localparam int DenW = SumW + 8 + 2 * $clog2(Window) + 20;

   logic signed [SumW-1:0] sum_ff, sum_in;
   logic [SqW-1:0]         sq_ff, sq_in;
   logic [NumW-1:0]        num_ff, num_in;
   logic [DenW-1:0]        den_ff, den_in;
   logic [DenW:0]          rem_ff, rem_in;
   logic [32:0]            quo_ff, quo_in;
   logic [31:0]            mean_ff, mean_in;
   logic                   zden_ff, zden_in;
   logic                   znum_ff, znum_in;

   logic signed [31:0]     samp_s;
   logic [31:0]            samp_abs;
   logic [SumW-1:0]        abs_t;
   logic [NumW-1:0]        var_w;
   logic [DenW:0]          rem_sh;

   assign samp_s = sample;
   assign samp_abs = samp_s[31] ? 32'(-samp_s) : sample;
   assign abs_t = sum_ff[SumW-1] ? SumW'(-sum_ff) : SumW'(sum_ff);
   assign var_w = NumW'(NumW'(sq_ff) * NumW'(Window)) - NumW'(NumW'(abs_t) * NumW'(abs_t));
   assign rem_sh = {rem_ff[DenW-1:0], num_ff[NumW-1]};

   // Clear, accumulate, prepare and divide, one step per cycle.
   always_comb begin
      sum_in = sum_ff;
      sq_in = sq_ff;
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      mean_in = mean_ff;
      zden_in = zden_ff;
      znum_in = znum_ff;
      if (ctrl.clear) begin
         sum_in = '0;
         sq_in = '0;
      end else if (ctrl.accum) begin
         sum_in = sum_ff + SumW'(samp_s);
         sq_in = sq_ff + SqW'(64'(samp_abs) * 64'(samp_abs));
      end else if (ctrl.prep) begin
         mean_in = 32'(sum_ff / Window);
         num_in = var_w << 16;
         den_in = DenW'(Window) * (DenW'(abs_t) * DenW'(256)
                  + DenW'(Window) * DenW'(epsilon));
         zden_in = (abs_t == '0) && (epsilon == '0);
         znum_in = (var_w == '0);
         rem_in = '0;
         quo_in = '0;
      end else if (ctrl.div_step) begin
         num_in = num_ff << 1;
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = (quo_ff << 1) | 33'd1;
         end else begin
            rem_in = rem_sh;
            quo_in = quo_ff << 1;
         end
         if (quo_ff[32]) quo_in[32] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      sq_ff <= sq_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      mean_ff <= mean_in;
      zden_ff <= zden_in;
      znum_ff <= znum_in;
   end

   // Sticky overflow bit saturates the quotient; a zero denominator gives zero or saturation.
   always_comb begin
      result.mean = mean_ff;
      if (zden_ff) result.term = znum_ff ? 32'd0 : SatMax;
      else if (quo_ff[32]) result.term = SatMax;
      else result.term = quo_ff[31:0];
   end

endmodule

// ===== rtl/core/wsd_merge.sv =====
// Merge stage: adds the three lane terms with saturation and compares to
// the threshold. Uses wsd_pkg.
module wsd_merge
   import wsd_pkg::*;
(
   input  lane_result_type [NumAxes-1:0] lanes,
   input  logic [31:0]                   threshold,
   output logic [31:0]                   sum,
   output logic                          stable
);

   logic [32:0] s1, s2;
   logic [31:0] s1_sat;

   // Saturate after each addition as the axes are combined.
   always_comb begin
      s1 = {1'b0, lanes[0].term} + {1'b0, lanes[1].term};
      s1_sat = s1[32] ? SatMax : s1[31:0];
      s2 = {1'b0, s1_sat} + {1'b0, lanes[2].term};
      sum = s2[32] ? SatMax : s2[31:0];
      stable = (sum <= threshold);
   end

endmodule

// ===== rtl/core/window_stability_detector_top.sv =====
// Window stability detector top level: ring buffer, sequencer, three lanes
// and the merge stage. Uses wsd_pkg, wsd_lane and wsd_merge.
//
// One item at a time. A missing sample or a not yet full window answers
// through the ST_OUT state without the lanes. For a full window, one ring
// entry per cycle is summed in all three lanes at once, then each lane's
// bit-serial divider runs one quotient bit per cycle over the numerator width.
// The result waits in an output register; the next item is taken once the
// result beat leaves.
module window_stability_detector_top
   import wsd_pkg::*;
#(
   parameter int Window = 5
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tuser,   // [0] sample_valid
   input  logic [95:0]  req_tdata,   // sample_x, sample_y, sample_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,   // [0] window_full, [1] stable
   output logic [127:0] rsp_tdata,   // variance_sum, mean_x, mean_y, mean_z
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam int IdxW = $clog2(Window);
   localparam int CntW = $clog2(Window + 1);
   localparam int NumW = 64 + $clog2(Window) + 1 + 24;
   localparam int DivW = $clog2(NumW + 1);

   state_type state_ff, state_in;
   logic [CntW-1:0] fill_ff, fill_in;
   logic [IdxW-1:0] slot_ff, slot_in;
   logic [IdxW-1:0] rd_ff, rd_in;
   logic [DivW-1:0] step_ff, step_in;
   logic [31:0] thr_ff, unst_ff;
   logic [EpsWidth-1:0] eps_ff;
   logic [31:0] win_ff [NumAxes][Window];
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_user_ff, rsp_user_in;
   logic [127:0] rsp_data_ff, rsp_data_in;
   logic wr_en;

   lane_ctrl_type ctrl;
   lane_result_type [NumAxes-1:0] lane_res;
   logic [31:0] merged_sum;
   logic merged_stable;

   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_user_ff;
   assign rsp_tdata = rsp_data_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 32'd167772;
         eps_ff <= 16'd17;
         unst_ff <= 32'd167772160;
      end else if (csr_valid) begin
         case (csr_index)
            RegThreshold: thr_ff <= csr_data;
            RegEpsilon: eps_ff <= csr_data[EpsWidth-1:0];
            RegUnstable: unst_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Sample ring.
   assign wr_en = req_tvalid && req_tready && req_tuser[0];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         win_ff[0][slot_ff] <= req_tdata[31:0];
         win_ff[1][slot_ff] <= req_tdata[63:32];
         win_ff[2][slot_ff] <= req_tdata[95:64];
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      slot_in = slot_ff;
      rd_in = rd_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in = rsp_user_ff;
      rsp_data_in = rsp_data_ff;
      ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               if (!req_tuser[0]) begin
                  fill_in = '0;
                  slot_in = '0;
                  state_in = ST_OUT;
               end else begin
                  slot_in = (slot_ff == IdxW'(Window - 1)) ? '0 : slot_ff + 1'b1;
                  if (fill_ff < CntW'(Window)) fill_in = fill_ff + 1'b1;
                  if (fill_ff >= CntW'(Window - 1)) begin
                     state_in = ST_ACCUM;
                     ctrl.clear = 1'b1;
                     rd_in = '0;
                  end else begin
                     state_in = ST_OUT;
                  end
               end
            end
         end
         ST_ACCUM: begin
            ctrl.accum = 1'b1;
            rd_in = rd_ff + 1'b1;
            if (rd_ff == IdxW'(Window - 1)) state_in = ST_PREP;
         end
         ST_PREP: begin
            ctrl.prep = 1'b1;
            step_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            ctrl.div_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == DivW'(NumW - 1)) state_in = ST_MERGE;
         end
         ST_MERGE: begin
            rsp_valid_in = 1'b1;
            rsp_user_in = {merged_stable, 1'b1};
            rsp_data_in = {lane_res[2].mean, lane_res[1].mean, lane_res[0].mean,
                           merged_sum};
            if (merged_stable) begin
               fill_in = '0;
               slot_in = '0;
            end
            state_in = ST_IDLE;
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_user_in = 2'b00;
            rsp_data_in = {96'd0, unst_ff};
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         slot_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         slot_ff <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_ff <= rd_in;
      step_ff <= step_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Axis lanes.
   for (genvar a = 0; a < NumAxes; a++) begin : g_lane
      wsd_lane #(.Window(Window)) u_lane (
         .clock(clock),
         .reset(reset),
         .ctrl(ctrl),
         .sample(win_ff[a][rd_ff]),
         .epsilon(eps_ff),
         .result(lane_res[a])
      );
   end

   wsd_merge u_merge (
      .lanes(lane_res),
      .threshold(thr_ff),
      .sum(merged_sum),
      .stable(merged_stable)
   );

   // Checks.
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CntW'(Window)) else $error("fill count overflow");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE) else $error("busy with result pending");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tuser[1] && rsp_valid_ff |-> rsp_tuser[0]) else $error("stable without full");

endmodule
